### hw/rtl/plu_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, command codes and the control word that the top level broadcasts to
// every storage cell of the list.
// ----------------------------------------------------------------------------
package plu_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 8;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOCATE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic                    insert_go;
        logic                    delete_go;
        logic                    locate_go;
        logic [CMP_W-1:0]        pos;
        logic [CMP_W-1:0]        count;
        logic signed [VAL_W-1:0] value;
    } plu_bcast_t;

endpackage

### hw/rtl/plu_cell.sv
// ----------------------------------------------------------------------------
// Positional list storage cell
// Holds one list entry. On an insert it takes its lower neighbour's entry or
// the new value, on a delete its upper neighbour's entry, and on a locate it
// flags a match when it lies inside the list and holds the wanted value.
// ----------------------------------------------------------------------------
module plu_cell (
    input  logic                             aclk,
    input  logic [plu_pkg::CMP_W-1:0]        ordinal,
    input  plu_pkg::plu_bcast_t              bcast,
    input  logic signed [plu_pkg::VAL_W-1:0] lower_entry,
    input  logic signed [plu_pkg::VAL_W-1:0] upper_entry,
    output logic signed [plu_pkg::VAL_W-1:0] entry,
    output logic                             match
);
    import plu_pkg::*;

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        priority if (bcast.insert_go && (ordinal > bcast.pos)) begin
            entry_next = lower_entry;
        end else if (bcast.insert_go && (ordinal == bcast.pos)) begin
            entry_next = bcast.value;
        end else if (bcast.delete_go && (ordinal >= bcast.pos)
                     && (ordinal < bcast.count)) begin
            entry_next = upper_entry;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = bcast.locate_go && (ordinal <= bcast.count)
                   && (entry_reg == bcast.value);

endmodule

### hw/rtl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values kept in a row of storage cells, with
// insert and delete by position and locate by value.
// Pipeline: the cells update at the input transfer and their match flags are
// registered in the p1 stage; the first-match encoder runs from p1 into the
// result register.
// Throughput: one command per cycle while the result side keeps up.
// Reset: the entry count and the handshake state clear; the list then reads
// as empty.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position [7:0], item_value [39:8]
    input  logic [1:0]  s_tuser,   // command [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // found_position [7:0], list_length [15:8]
    output logic        m_tuser    // ok [0]
);
    import plu_pkg::*;

    logic                    accept;
    logic                    out_free;
    cmd_t                    cmd;
    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic                    ins_ok;
    logic                    del_ok;
    plu_bcast_t              bcast;

    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;

    logic signed [VAL_W-1:0] ent [CAPACITY];
    logic [CAPACITY-1:0]     match_vec;

    logic                    p1_valid_reg;
    logic                    p1_valid_next;
    logic                    p1_ok_reg;
    logic                    p1_locate_reg;
    logic [CAPACITY-1:0]     p1_match_reg;
    logic [LEN_W-1:0]        p1_len_reg;

    logic [IDX_W-1:0]        first_idx;
    logic                    any_match;
    logic [CMP_W-1:0]        first_ord;

    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    m_ok_reg;
    logic [LEN_W-1:0]        m_found_reg;
    logic [LEN_W-1:0]        m_len_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign cmd     = cmd_t'(s_tuser);
    assign pos_ext = CMP_W'(s_tdata[POS_W-1:0]);
    assign cnt_ext = CMP_W'(cnt_reg);

    assign ins_ok = (cmd == CMD_INSERT) && (pos_ext != '0)
                    && (pos_ext <= cnt_ext + CMP_W'(1))
                    && (cnt_ext < CMP_W'(CAPACITY));
    assign del_ok = (cmd == CMD_DELETE) && (pos_ext != '0) && (pos_ext <= cnt_ext);

    always_comb begin
        bcast.insert_go = accept && ins_ok;
        bcast.delete_go = accept && del_ok;
        bcast.locate_go = accept && (cmd == CMD_LOCATE);
        bcast.pos       = pos_ext;
        bcast.count     = cnt_ext;
        bcast.value     = s_tdata[POS_W +: VAL_W];
    end

    always_comb begin
        priority if (bcast.insert_go) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (bcast.delete_go) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] lower_e;
        logic signed [VAL_W-1:0] upper_e;

        if (g == 0) begin : g_first
            assign lower_e = bcast.value;
        end else begin : g_mid_lo
            assign lower_e = ent[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign upper_e = ent[g];
        end else begin : g_mid_hi
            assign upper_e = ent[g+1];
        end

        plu_cell u_cell (
            .aclk        (aclk),
            .ordinal     (CMP_W'(g + 1)),
            .bcast       (bcast),
            .lower_entry (lower_e),
            .upper_entry (upper_e),
            .entry       (ent[g]),
            .match       (match_vec[g])
        );
    end

    always_comb begin
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (out_free) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
    end

    always_comb begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (p1_match_reg[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    assign any_match = |p1_match_reg;
    assign first_ord = CMP_W'(first_idx) + CMP_W'(1);

    assign m_valid_next = out_free ? p1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_ok_reg     <= ins_ok || del_ok;
            p1_locate_reg <= (cmd == CMD_LOCATE);
            p1_match_reg  <= match_vec;
            p1_len_reg    <= cnt_next[LEN_W-1:0];
        end
        if (out_free && p1_valid_reg) begin
            m_len_reg <= p1_len_reg;
            if (p1_locate_reg) begin
                m_ok_reg    <= any_match;
                m_found_reg <= any_match ? first_ord[LEN_W-1:0] : '0;
            end else begin
                m_ok_reg    <= p1_ok_reg;
                m_found_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_len_reg, m_found_reg};
    assign m_tuser  = m_ok_reg;

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds the list capacity.");

    a_insert_count : assert property (@(posedge aclk) disable iff (!aresetn)
        bcast.insert_go |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("Accepted insert did not grow the list by one.");

    a_delete_count : assert property (@(posedge aclk) disable iff (!aresetn)
        bcast.delete_go |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("Accepted delete did not shrink the list by one.");

    a_match_locate : assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_locate_reg) |-> (p1_match_reg == '0))
        else $error("Match flags raised by a command other than locate.");

    a_found_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_found_reg == '0) || m_ok_reg))
        else $error("Result carries a found position without success.");

endmodule
